>>> sv/palette_gray_pixel_converter_defines.svh
// Assertion macros shared by the palette and gray pixel converter modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PALETTE_GRAY_PIXEL_CONVERTER_DEFINES_SVH
`define PALETTE_GRAY_PIXEL_CONVERTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PGPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pgpc_pkg.sv
// Package for the palette and gray pixel converter: payload structs, codes,
// register indexes and arithmetic constants. It depends on nothing else.
package pgpc_pkg;

  localparam int DEFAULT_PALETTE_DEPTH = 256;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int DIST_W      = 18;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_GRAY    = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE          = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_COUNT = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PACK_NIBBLES  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 4'd3;

  localparam logic [15:0] GRAY_R = 16'd77;
  localparam logic [15:0] GRAY_G = 16'd150;
  localparam logic [15:0] GRAY_B = 16'd29;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic       op;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       row_end;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_t;

endpackage

>>> sv/pgpc_palette_ram.sv
// Palette memory: one write port and one read port with registered read data.
// Depends on pgpc_pkg for the colour type.
module pgpc_palette_ram #(
  parameter int PALETTE_DEPTH = pgpc_pkg::DEFAULT_PALETTE_DEPTH,
  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  pgpc_pkg::color_t   wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output pgpc_pkg::color_t   rd_data
);

  pgpc_pkg::color_t mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/pgpc_search.sv
// Nearest palette entry search: walks the palette memory one entry per cycle
// through a read, square and compare pipeline. Depends on pgpc_pkg.
`include "palette_gray_pixel_converter_defines.svh"

module pgpc_search #(
  parameter int PALETTE_DEPTH = pgpc_pkg::DEFAULT_PALETTE_DEPTH,
  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1,
  localparam int CNT_W = IDX_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  pgpc_pkg::color_t color,
  input  logic [CNT_W-1:0] count,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  pgpc_pkg::color_t rd_data,
  output logic             done,
  output logic [IDX_W-1:0] best
);

  logic                        busy;
  logic                        issuing;
  logic [CNT_W-1:0]            issue_cnt;
  logic [CNT_W-1:0]            count_q;
  pgpc_pkg::color_t            pix;
  logic                        v1;
  logic [IDX_W-1:0]            idx1;
  logic                        v2;
  logic [IDX_W-1:0]            idx2;
  logic [15:0]                 sq_r;
  logic [15:0]                 sq_g;
  logic [15:0]                 sq_b;
  logic                        found;
  logic [pgpc_pkg::DIST_W-1:0] best_dist;
  logic [pgpc_pkg::DIST_W-1:0] cand_dist;
  logic [CNT_W-1:0]            issue_inc;
  logic [7:0]                  ad_r;
  logic [7:0]                  ad_g;
  logic [7:0]                  ad_b;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign rd_en     = issuing;
  assign rd_addr   = issue_cnt[IDX_W-1:0];
  assign issue_inc = issue_cnt + CNT_W'(1);
  assign ad_r      = abs_diff(pix.red, rd_data.red);
  assign ad_g      = abs_diff(pix.green, rd_data.green);
  assign ad_b      = abs_diff(pix.blue, rd_data.blue);
  assign cand_dist = pgpc_pkg::DIST_W'(sq_r) + pgpc_pkg::DIST_W'(sq_g)
                   + pgpc_pkg::DIST_W'(sq_b);
  // The search is over once nothing is being issued and the pipeline is empty.
  assign done      = busy && !issuing && !v1 && !v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      issuing <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      found   <= 1'b0;
    end else if (start) begin
      busy      <= 1'b1;
      issuing   <= (count != '0);
      issue_cnt <= '0;
      count_q   <= count;
      pix       <= color;
      v1        <= 1'b0;
      v2        <= 1'b0;
      found     <= 1'b0;
      best      <= '0;
    end else begin
      if (issuing) begin
        issue_cnt <= issue_inc;
        issuing   <= (issue_inc < count_q);
      end
      v1   <= issuing;
      idx1 <= issue_cnt[IDX_W-1:0];
      v2   <= v1;
      idx2 <= idx1;
      sq_r <= 16'(ad_r) * 16'(ad_r);
      sq_g <= 16'(ad_g) * 16'(ad_g);
      sq_b <= 16'(ad_b) * 16'(ad_b);
      // A strict compare keeps the lower index on a tie.
      if (v2 && (!found || cand_dist < best_dist)) begin
        found     <= 1'b1;
        best_dist <= cand_dist;
        best      <= idx2;
      end
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  `PGPC_ASSERT_NOW(a_start_when_free, start, !busy, "search started while busy")
  `PGPC_ASSERT_NOW(a_issue_in_range, issuing, issue_cnt < count_q, "address past count")
  `PGPC_ASSERT_NOW(a_pipe_in_search, v1 || v2, busy, "pipeline active outside a search")
  `PGPC_ASSERT_NEXT(a_done_releases, done, !busy, "search did not finish after done")

endmodule

>>> sv/palette_gray_pixel_converter.sv
// A load writes the palette memory and stays in ST_IDLE. A gray pixel goes to ST_EMIT;
// a palette pixel starts a search over N entries, N being palette_count saturated at
// PALETTE_DEPTH, and goes through ST_SEARCH to ST_EMIT, or back to ST_IDLE when its index
// is only held. The emit waits while the output register is full; items stall until idle.
// Reset (rst, synchronous) clears control state and counters, not payload or palette memory.
// Depends on pgpc_pkg, pgpc_palette_ram, pgpc_search and the defines header.
`include "palette_gray_pixel_converter_defines.svh"

module palette_gray_pixel_converter #(
  parameter int PALETTE_DEPTH = pgpc_pkg::DEFAULT_PALETTE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  pgpc_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output pgpc_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pgpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pgpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [8:0] DEPTH_CNT = 9'(PALETTE_DEPTH);

  pgpc_pkg::state_t state;
  pgpc_pkg::state_t state_next;

  logic        mode;
  logic [8:0]  palette_count;
  logic        pack_nibbles;
  logic [15:0] image_width;
  logic [15:0] column_count;
  logic [3:0]  held_nibble;
  logic        col_odd;
  logic        row_last;
  logic [7:0]  res_byte;
  logic        res_last;

  logic             item_fire;
  logic             load_fire;
  logic             gray_fire;
  logic             load_we;
  logic             search_start;
  logic             search_done;
  logic             emit_fire;
  logic [IDX_W-1:0] best;
  logic [7:0]       best_byte;
  logic [CNT_W-1:0] search_count;
  logic [15:0]      width_eff;
  logic [16:0]      col_inc;
  logic             last;
  logic [15:0]      gray_sum;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  pgpc_pkg::color_t rd_data;
  pgpc_pkg::color_t item_color;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != pgpc_pkg::ST_IDLE);
  assign item_fire  = item_valid && !item_stall;
  assign load_fire  = item_fire && (item.op == pgpc_pkg::OP_LOAD);
  assign gray_fire  = item_fire && (item.op == pgpc_pkg::OP_PIXEL)
                   && (mode == pgpc_pkg::MODE_GRAY);
  assign item_color = '{red: item.red, green: item.green, blue: item.blue};
  assign load_we    = item_fire && (item.op == pgpc_pkg::OP_LOAD)
                   && ({1'b0, item.entry_index} < DEPTH_CNT);

  assign search_count = (palette_count > DEPTH_CNT) ? CNT_W'(PALETTE_DEPTH)
                                                   : palette_count[CNT_W-1:0];
  assign width_eff = (image_width == '0) ? 16'd1 : image_width;
  assign col_inc   = {1'b0, column_count} + 17'd1;
  assign last      = (col_inc >= {1'b0, width_eff});
  assign gray_sum  = 16'(item.red) * pgpc_pkg::GRAY_R + 16'(item.green) * pgpc_pkg::GRAY_G
                   + 16'(item.blue) * pgpc_pkg::GRAY_B;
  assign best_byte = 8'(best);

  always_comb begin
    state_next   = state;
    search_start = 1'b0;
    emit_fire    = 1'b0;
    case (state)
      pgpc_pkg::ST_IDLE: begin
        if (item_fire && item.op == pgpc_pkg::OP_PIXEL) begin
          if (mode == pgpc_pkg::MODE_GRAY) begin
            state_next = pgpc_pkg::ST_EMIT;
          end else begin
            search_start = 1'b1;
            state_next   = pgpc_pkg::ST_SEARCH;
          end
        end
      end
      pgpc_pkg::ST_SEARCH: begin
        if (search_done) begin
          // An even column that does not end the row is only held.
          if (pack_nibbles && !col_odd && !row_last) begin
            state_next = pgpc_pkg::ST_IDLE;
          end else begin
            state_next = pgpc_pkg::ST_EMIT;
          end
        end
      end
      pgpc_pkg::ST_EMIT: begin
        if (!result_valid || !result_stall) begin
          emit_fire  = 1'b1;
          state_next = pgpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pgpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= pgpc_pkg::MODE_PALETTE;
      palette_count <= '0;
      pack_nibbles  <= 1'b0;
      image_width   <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pgpc_pkg::CFG_MODE:          mode          <= cfg_data[0];
        pgpc_pkg::CFG_PALETTE_COUNT: palette_count <= cfg_data[8:0];
        pgpc_pkg::CFG_PACK_NIBBLES:  pack_nibbles  <= cfg_data[0];
        pgpc_pkg::CFG_IMAGE_WIDTH:   image_width   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      held_nibble  <= '0;
    end else begin
      if (item_fire && item.op == pgpc_pkg::OP_PIXEL) begin
        column_count <= last ? 16'd0 : col_inc[15:0];
      end
      if (state == pgpc_pkg::ST_SEARCH && search_done && pack_nibbles && !col_odd) begin
        held_nibble <= best_byte[3:0];
      end
    end
  end

  // Per-pixel payload captured at acceptance and at the end of the search.
  always_ff @(posedge clk) begin
    if (item_fire && item.op == pgpc_pkg::OP_PIXEL) begin
      col_odd  <= column_count[0];
      row_last <= last;
      res_last <= last;
      res_byte <= gray_sum[15:8];
    end else if (state == pgpc_pkg::ST_SEARCH && search_done) begin
      if (pack_nibbles) begin
        res_byte <= col_odd ? {held_nibble, best_byte[3:0]} : {best_byte[3:0], 4'd0};
      end else begin
        res_byte <= best_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_fire) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      result <= '{out_byte: res_byte, row_end: res_last};
    end
  end

  // Loads happen only while idle and the search starts after, so the
  // memory never sees a read and a write of one entry in the same cycle.
  pgpc_palette_ram #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (item.entry_index[IDX_W-1:0]),
    .wr_data (item_color),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pgpc_search #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (search_start),
    .color   (item_color),
    .count   (search_count),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (search_done),
    .best    (best)
  );

  `PGPC_ASSERT_NEXT(a_load_no_result, load_fire, state == pgpc_pkg::ST_IDLE, "load item left idle")
  `PGPC_ASSERT_NEXT(a_gray_emits, gray_fire, state == pgpc_pkg::ST_EMIT, "gray pixel not emitted")
  `PGPC_ASSERT_NOW(a_done_in_search, search_done, state == pgpc_pkg::ST_SEARCH, "done outside search")

endmodule
